### hdl/atdf_pkg.sv
// Package for the ambient temperature drop filter.
// Holds the shared constants, register index codes and command codes.
// No dependencies; compiled first.
`default_nettype none

package atdf_pkg;

    localparam int DEFAULT_FACTOR = 10;
    localparam int DISABLE_LEVEL  = 254;

    localparam logic [7:0] DELTA_RESET  = 8'd255;
    localparam logic [7:0] START_RESET  = 8'd0;
    localparam int         FACTOR_RESET = 10;
    localparam logic [7:0] FACTOR_MAX   = 8'd100;

    // Division by 100 is done as a multiply by ceil(2^29 / 100). The shift is
    // large enough that quotient and remainder test are exact for products
    // below 2^22.
    localparam int          RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_100   = 23'd5368710;
    localparam int          WGT_W       = 30;

    localparam int TEMP_W = 15;

    typedef enum logic [1:0] {
        REG_PREWARN_DELTA = 2'd0,
        REG_START_TEMP    = 2'd1,
        REG_FILTER_FACTOR = 2'd2
    } cfg_idx_t;

    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_CYCLIC = 1'b1;

endpackage

`default_nettype wire

### hdl/atdf_if.sv
// Channel interfaces of the ambient temperature drop filter.
// Depends on atdf_pkg for the field widths.
`default_nettype none

interface atdf_item_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic signed [7:0] ambient;

    modport source (output valid, output cmd, output ambient, input ready);
    modport sink   (input valid, input cmd, input ambient, output ready);
endinterface

interface atdf_result_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   warn;
    logic signed [atdf_pkg::TEMP_W-1:0]     filtered_temp;
    logic                                   filter_valid;

    modport source (output valid, output warn, output filtered_temp, output filter_valid,
                    input ready);
    modport sink   (input valid, input warn, input filtered_temp, input filter_valid,
                    output ready);
endinterface

interface atdf_cfg_if;
    logic                 valid;
    logic                 ready;
    atdf_pkg::cfg_idx_t   index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/ambient_temp_drop_filter_warn.sv
// Top level of the ambient temperature drop filter with low-temperature warning.
// Depends on atdf_pkg and the channel interfaces in atdf_if.sv.
//
//   channel  | dir | payload                                  | transfer
//   ---------+-----+------------------------------------------+------------------
//   item     | in  | cmd, ambient                             | valid & ready
//   result   | out | warn, filtered_temp, filter_valid        | valid & ready
//   cfg      | in  | index, data (prewarn, start, factor)     | valid & ready
//
// One item per cycle sustained while results are taken; results are registered.
// The filter state update is combinational: one 15 x 30 bit multiply by the
// pre-scaled blend weight plus a compare and subtract sets the clock period.
// A stalled result holds in the output register while one more item waits in
// the input register. Reset clears the filter state and loads register defaults.
// Configuration writes are always taken and are meant for an idle block.
`default_nettype none

module ambient_temp_drop_filter_warn #(
    parameter int DEFAULT_FACTOR = atdf_pkg::DEFAULT_FACTOR,
    parameter int DISABLE_LEVEL  = atdf_pkg::DISABLE_LEVEL
) (
    input  wire            clk,
    input  wire            rst_n,
    atdf_item_if.sink      item,
    atdf_result_if.source  result,
    atdf_cfg_if.sink       cfg
);

    localparam int TW = atdf_pkg::TEMP_W;
    localparam int SH = atdf_pkg::RECIP_SHIFT;
    localparam int WW = atdf_pkg::WGT_W;
    localparam int PW = TW + WW;
    localparam logic [WW-1:0] WGT_RESET =
        WW'(atdf_pkg::FACTOR_RESET) * WW'(atdf_pkg::RECIP_100);

    // Configuration registers. The blend weight is stored already multiplied
    // by the reciprocal of 100.
    logic [7:0]          delta_reg;
    logic signed [7:0]   start_reg;
    logic [WW-1:0]       wgt_reg;
    logic [7:0]          factor_eff;
    logic [WW-1:0]       wgt_next;

    // Input register
    logic                in_valid_reg;
    logic                cmd_reg;
    logic signed [7:0]   amb_reg;

    // Filter state
    logic signed [TW-1:0] filt_reg;
    logic                 ok_reg;
    logic                 warn_reg;
    logic signed [TW-1:0] filt_next;
    logic                 ok_next;
    logic                 warn_next;

    // Output register
    logic                 out_valid_reg;
    logic                 out_warn_reg;
    logic signed [TW-1:0] out_temp_reg;
    logic                 out_ok_reg;

    logic                 advance;
    logic                 enabled;
    logic signed [15:0]   amb100;
    logic signed [16:0]   amb100_p50;
    logic signed [9:0]    thr_deg;
    logic signed [16:0]   thr;
    logic                 below_thr;
    logic                 below_round;
    logic signed [16:0]   gap;
    logic [TW-1:0]        gap_mag;
    logic [PW-1:0]        prod;
    logic [15:0]          quot;
    logic                 exact;
    logic signed [16:0]   quot_s;
    logic signed [16:0]   old_s;
    logic                 total_neg;
    logic signed [16:0]   step;
    logic signed [16:0]   blend;

    assign cfg.ready = 1'b1;

    assign factor_eff = (cfg.data > atdf_pkg::FACTOR_MAX) ? 8'(DEFAULT_FACTOR) : cfg.data;
    assign wgt_next   = WW'(factor_eff) * WW'(atdf_pkg::RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= atdf_pkg::DELTA_RESET;
            start_reg <= atdf_pkg::START_RESET;
            wgt_reg   <= WGT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                atdf_pkg::REG_PREWARN_DELTA: delta_reg <= cfg.data;
                atdf_pkg::REG_START_TEMP:    start_reg <= cfg.data;
                atdf_pkg::REG_FILTER_FACTOR: wgt_reg   <= wgt_next;
                default:                     ;
            endcase
        end
    end

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            cmd_reg <= item.cmd;
            amb_reg <= item.ambient;
        end
    end

    assign enabled = delta_reg < 8'(DISABLE_LEVEL);

    assign amb100     = amb_reg * 16'sd100;
    assign amb100_p50 = 17'(amb100) + 17'sd50;
    assign thr_deg    = 10'(start_reg) - $signed({2'b00, delta_reg});
    assign thr        = thr_deg * 17'sd100;
    assign below_thr  = filt_reg < thr;

    // Comparing against the filter value rounded half away from zero, done
    // without the division: the boundary moves by half a degree.
    assign below_round = filt_reg[TW-1] ? (filt_reg > amb100_p50) : (filt_reg >= amb100_p50);

    // Blend: new = trunc((100 * old - f * gap) / 100) with gap = old - 100 * ambient,
    // which is positive whenever the blend is taken.
    assign gap     = 17'(filt_reg) - 17'(amb100);
    assign gap_mag = gap[TW-1:0];
    assign prod    = PW'(gap_mag) * PW'(wgt_reg);
    assign quot    = prod[PW-1:SH];
    assign exact   = prod[SH-1:0] < SH'(atdf_pkg::RECIP_100);
    assign quot_s  = $signed({1'b0, quot});
    assign old_s   = 17'(filt_reg);

    // The total is negative when f * gap exceeds 100 * old; truncation toward
    // zero then rounds the quotient down, otherwise up.
    assign total_neg = exact ? (quot_s > old_s) : (quot_s >= old_s);
    assign step      = quot_s + $signed({16'b0, !exact && !total_neg});
    assign blend     = old_s - step;

    always_comb
    begin
        filt_next = filt_reg;
        ok_next   = ok_reg;
        warn_next = warn_reg;
        if (!enabled)
        begin
            warn_next = 1'b1;
            if (cmd_reg == atdf_pkg::CMD_INIT)
            begin
                ok_next   = 1'b0;
                filt_next = '0;
            end
        end
        else if (!ok_reg)
        begin
            filt_next = TW'(start_reg * 16'sd100);
            ok_next   = 1'b1;
            warn_next = 1'b0;
        end
        else if (cmd_reg == atdf_pkg::CMD_INIT)
        begin
            warn_next = below_thr;
        end
        else if (amb_reg < start_reg)
        begin
            if (below_round)
            begin
                filt_next = blend[TW-1:0];
                // Threshold check on the new value; the threshold is fixed
                // here, so compare the blended value directly.
                warn_next = blend < thr;
            end
            else
            begin
                filt_next = amb100[TW-1:0];
                warn_next = 1'b1;
            end
        end
        else
        begin
            filt_next = amb100[TW-1:0];
            warn_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg      <= '0;
            ok_reg        <= 1'b0;
            warn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                filt_reg      <= filt_next;
                ok_reg        <= ok_next;
                warn_reg      <= warn_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_warn_reg <= warn_next;
            out_temp_reg <= ok_next ? filt_next : '0;
            out_ok_reg   <= ok_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.warn          = out_warn_reg;
    assign result.filtered_temp = out_temp_reg;
    assign result.filter_valid  = out_ok_reg;

    // An empty output register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("input stalled while output register empty");

    // An invalid filter always reports a zero temperature.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_temp_reg == '0))
        else $error("invalid filter reports nonzero temperature");

    // A blended value lies between the ambient and the previous value.
    a_blend_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && enabled && ok_reg && (cmd_reg == atdf_pkg::CMD_CYCLIC)
         && (amb_reg < start_reg) && below_round)
        |=> ((filt_reg <= $past(filt_reg)) && (filt_reg >= $past(amb100))))
        else $error("blended value out of range");

    // A disabled block always ends an item with the warning set.
    a_disabled_warn: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !enabled) |=> warn_reg)
        else $error("warning not set while disabled");

    // A warm ambient snaps the filter and clears the warning.
    a_warm_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && enabled && ok_reg && (cmd_reg == atdf_pkg::CMD_CYCLIC)
         && (amb_reg >= start_reg))
        |=> ((filt_reg == $past(amb100[TW-1:0])) && !warn_reg))
        else $error("filter did not snap to warm ambient");

endmodule

`default_nettype wire

### test/ambient_temp_drop_filter_warn_tb.sv
// Self-checking testbench for the ambient temperature drop filter with warning.
// Depends on atdf_pkg, the channel interfaces in atdf_if.sv and the top level;
// it predicts every result in-line and compares the results in transfer order.
`default_nettype none

module ambient_temp_drop_filter_warn_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PERCENT = 28;

    typedef struct packed {
        logic                               warn;
        logic signed [atdf_pkg::TEMP_W-1:0] temp;
        logic                               valid;
    } reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    atdf_item_if   item_ch();
    atdf_result_if result_ch();
    atdf_cfg_if    cfg_ch();

    ambient_temp_drop_filter_warn DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Register copies and filter state as the block should hold them.
    int delta_q     = 255;
    int start_q     = 0;
    int factor_q    = 10;
    int filt_q      = 0;
    bit filt_ok_q   = 1'b0;
    bit warn_q      = 1'b0;

    reading_t              expected_readings[$];
    int                    fail_count  = 0;
    int                    cycle_count = 0;
    bit                    send_idle   = 1'b1;
    bit                    recv_idle   = 1'b1;
    logic signed [7:0]     last_ambient = '0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic reading_t predict_reading(input logic cmd,
                                                 input logic signed [7:0] ambient);
        int       amb;
        int       thr;
        int       rounded;
        int       f;
        reading_t r;
        amb = ambient;
        // The threshold is compared at full width, without any 16-bit wrap.
        thr = (start_q - delta_q) * 100;
        if (delta_q >= atdf_pkg::DISABLE_LEVEL)
        begin
            warn_q = 1'b1;
            if (cmd == atdf_pkg::CMD_INIT)
            begin
                filt_ok_q = 1'b0;
                filt_q    = 0;
            end
        end
        else if (!filt_ok_q)
        begin
            filt_q    = start_q * 100;
            filt_ok_q = 1'b1;
            warn_q    = 1'b0;
        end
        else if (cmd == atdf_pkg::CMD_INIT)
        begin
            warn_q = filt_q < thr;
        end
        else if (amb < start_q)
        begin
            // Round the filtered value to whole degrees, half away from zero.
            rounded = (filt_q < 0) ? (filt_q - 50) / 100 : (filt_q + 50) / 100;
            if (amb < rounded)
            begin
                f      = (factor_q > int'(atdf_pkg::FACTOR_MAX)) ? atdf_pkg::DEFAULT_FACTOR
                                                                  : factor_q;
                filt_q = (f * amb * 100 + (100 - f) * filt_q) / 100;
                warn_q = filt_q < thr;
            end
            else
            begin
                filt_q = amb * 100;
                warn_q = 1'b1;
            end
        end
        else
        begin
            filt_q = amb * 100;
            warn_q = 1'b0;
        end
        r.warn  = warn_q;
        r.temp  = filt_ok_q ? filt_q[atdf_pkg::TEMP_W-1:0] : '0;
        r.valid = filt_ok_q;
        return r;
    endfunction

    // Result side: random stalls and the in-order comparison.
    always @(posedge clk)
    begin
        reading_t want;
        reading_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.warn  = result_ch.warn;
            got.temp  = result_ch.filtered_temp;
            got.valid = result_ch.filter_valid;
            if (expected_readings.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, expected none,", $time,
                         " got warn=%0d temp=%0d valid=%0d",
                         got.warn, got.temp, got.valid);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.warn !== want.warn || got.temp !== want.temp
                    || got.valid !== want.valid)
                begin
                    fail_count++;
                    $display("%0t: result mismatch, expected warn=%0d temp=%0d valid=%0d,",
                             $time, want.warn, want.temp, want.valid,
                             " got warn=%0d temp=%0d valid=%0d",
                             got.warn, got.temp, got.valid);
                end
            end
        end
        result_ch.ready <= !(recv_idle && $urandom_range(99) < IDLE_PERCENT);
    end

    task automatic send_reading(input logic cmd, input logic signed [7:0] ambient);
        while (send_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.cmd     <= cmd;
        item_ch.ambient <= ambient;
        do @(posedge clk); while (!item_ch.ready);
        expected_readings.push_back(predict_reading(cmd, ambient));
        last_ambient = ambient;
    endtask

    // With nothing expected the input is already idle and is left alone.
    task automatic wait_all_readings();
        if (expected_readings.size() != 0)
        begin
            item_ch.valid <= 1'b0;
            while (expected_readings.size() != 0)
                @(posedge clk);
        end
    endtask

    // All three registers are written back to back while the block is idle.
    task automatic apply_settings(input logic [7:0] delta, input logic signed [7:0] start,
                                  input logic [7:0] factor);
        atdf_pkg::cfg_idx_t idx [3];
        logic [7:0]         val [3];
        idx = '{atdf_pkg::REG_PREWARN_DELTA, atdf_pkg::REG_START_TEMP,
                atdf_pkg::REG_FILTER_FACTOR};
        val = '{delta, start, factor};
        wait_all_readings();
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        delta_q  = delta;
        start_q  = start;
        factor_q = factor;
    endtask

    task automatic test_disabled_block();
        send_reading(atdf_pkg::CMD_INIT, -8'sd128);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd127);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd0);
        apply_settings(8'd254, 8'sd0, 8'd10);
        send_reading(atdf_pkg::CMD_INIT, 8'sd1);
    endtask

    task automatic test_enabled_paths();
        // Factor above 100 falls back to the default weight.
        apply_settings(8'd10, 8'sd20, 8'd255);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd5);
        send_reading(atdf_pkg::CMD_INIT, 8'sd0);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd30);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd20);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd10);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd15);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd19);
        send_reading(atdf_pkg::CMD_INIT, 8'sd0);
        // A disabled init invalidates the filter; the next enabled item reloads it.
        apply_settings(8'd255, 8'sd20, 8'd255);
        send_reading(atdf_pkg::CMD_INIT, 8'sd0);
        apply_settings(8'd0, -8'sd128, 8'd0);
        send_reading(atdf_pkg::CMD_CYCLIC, -8'sd128);
        send_reading(atdf_pkg::CMD_CYCLIC, -8'sd128);
        send_reading(atdf_pkg::CMD_CYCLIC, 8'sd127);
    endtask

    task automatic test_config_extremes();
        apply_settings(8'd253, 8'sd127, 8'd100);
        send_reading(atdf_pkg::CMD_INIT, 8'sd3);
        send_reading(atdf_pkg::CMD_CYCLIC, -8'sd128);
        send_reading(atdf_pkg::CMD_CYCLIC, -8'sd100);
        // A negative filtered value is rounded half away from zero, then blended.
        apply_settings(8'd0, 8'sd127, 8'd50);
        send_reading(atdf_pkg::CMD_CYCLIC, -8'sd1);
        send_reading(atdf_pkg::CMD_CYCLIC, -8'sd51);
    endtask

    task automatic run_random_phase(input int count);
        logic [7:0]        delta;
        logic signed [7:0] start;
        logic [7:0]        factor;
        int                pick;
        int                amb;
        pick = $urandom_range(99);
        if (pick < 15)       delta = 8'($urandom_range(254, 255));
        else if (pick < 25)  delta = 8'd0;
        else if (pick < 35)  delta = 8'd253;
        else                 delta = 8'($urandom_range(0, 253));
        pick = $urandom_range(99);
        if (pick < 15)       start = -8'sd128;
        else if (pick < 30)  start = 8'sd127;
        else                 start = 8'($urandom_range(0, 255));
        pick = $urandom_range(99);
        if (pick < 10)       factor = 8'd0;
        else if (pick < 20)  factor = 8'd100;
        else if (pick < 30)  factor = 8'($urandom_range(101, 255));
        else                 factor = 8'($urandom_range(0, 100));
        apply_settings(delta, start, factor);
        last_ambient = start;
        for (int n = 0; n < count; n++)
        begin
            // Mostly a slow downward drift, so that the blend path is taken often.
            if ($urandom_range(99) < 35)
                amb = $signed(8'($urandom_range(0, 255)));
            else
                amb = int'(last_ambient) + int'($urandom_range(0, 6)) - 4;
            if (amb < -128) amb = -128;
            if (amb > 127)  amb = 127;
            send_reading(($urandom_range(99) < 15) ? atdf_pkg::CMD_INIT
                                                   : atdf_pkg::CMD_CYCLIC, 8'(amb));
            if ($urandom_range(99) < 2)
                wait_all_readings();
        end
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 12; p++)
            run_random_phase(140);
    endtask

    task automatic test_unthrottled();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        run_random_phase(300);
        wait_all_readings();
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial
    begin
        item_ch.valid   = 1'b0;
        item_ch.cmd     = atdf_pkg::CMD_INIT;
        item_ch.ambient = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = atdf_pkg::REG_PREWARN_DELTA;
        cfg_ch.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_disabled_block();
        test_enabled_paths();
        test_config_extremes();
        test_random_settings();
        test_unthrottled();

        wait_all_readings();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/atdf_pkg.sv
hdl/atdf_if.sv
hdl/ambient_temp_drop_filter_warn.sv
test/ambient_temp_drop_filter_warn_tb.sv
